### design/sqbg_pkg.sv
// Shared types, constants and helper functions for the send queue guard.
`timescale 1ns / 1ps

package sqbg_pkg;

  // Queue geometry and field widths.
  localparam int QUEUE_DEPTH = 64;
  localparam int HANDLE_BITS = 16;
  localparam int BYTES_W     = 24;
  localparam int TOTAL_W     = 32;
  localparam int MAXMSG_W    = 7;
  localparam int TIMER_W     = 32;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = HANDLE_BITS + BYTES_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);

  // Command codes of an input beat.
  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DONE = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_MSG   = 2'd0,
    CFG_MAX_BYTES = 2'd1,
    CFG_TIMEOUT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    mode_t                   mode;
    logic [HANDLE_BITS-1:0]  msg_handle;
    logic [BYTES_W-1:0]      msg_bytes;
  } in_t;

  typedef struct packed {
    logic                    start_write;
    logic [HANDLE_BITS-1:0]  write_handle;
    logic [BYTES_W-1:0]      write_bytes;
    logic                    close_event;
    logic                    session_closed;
    logic                    dropped;
    logic [MAXMSG_W-1:0]     queued_messages;
    logic [TOTAL_W-1:0]      total_bytes;
    logic                    stall_pending;
  } out_t;

  typedef struct packed {
    logic [MAXMSG_W-1:0]     max_messages;
    logic [TOTAL_W-1:0]      max_bytes;
    logic [TIMER_W-1:0]      stall_timeout_ticks;
  } cfg_t;

  // One stored message.
  typedef struct packed {
    logic [HANDLE_BITS-1:0]  handle;
    logic [BYTES_W-1:0]      bytes;
  } entry_t;

  // Request from the controller to the message memory.
  typedef struct packed {
    logic                    we;
    logic [PTR_W-1:0]        waddr;
    entry_t                  wdata;
    logic                    re;
    logic [PTR_W-1:0]        raddr;
  } ram_req_t;

  // Circular pointer advance for any queue depth.
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // True when an enabled limit is exceeded.
  function automatic logic over_limit(input logic [CNT_W-1:0]   cnt,
                                      input logic [TOTAL_W-1:0] total,
                                      input cfg_t               cfg);
    logic msg_over;
    logic byte_over;
    msg_over  = (cfg.max_messages != '0) && (32'(cnt) > 32'(cfg.max_messages));
    byte_over = (cfg.max_bytes != '0) && (total > cfg.max_bytes);
    return msg_over || byte_over;
  endfunction

endpackage

### design/sqbg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module sqbg_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/sqbg_ctrl.sv
// Queue controller: command sequencer, pointers, totals, stall timer and result register.
`timescale 1ns / 1ps

module sqbg_ctrl
  import sqbg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_start,
  output logic     in_busy,
  input  in_t      in_data,
  input  cfg_t     cfg,
  output ram_req_t ram_req,
  input  entry_t   ram_rdata,
  output logic     out_strobe,
  output out_t     out_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_EXEC
  } state_t;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               writing_r, writing_nxt;
  logic               armed_r, armed_nxt;
  logic [TIMER_W-1:0] ticks_r, ticks_nxt;
  logic               closed_r, closed_nxt;
  logic               strobe_r, strobe_nxt;
  in_t                item_r, item_nxt;
  logic [BYTES_W-1:0] len_r, len_nxt;
  out_t               out_r, out_nxt;

  logic [TOTAL_W:0]   sum_wide;
  logic               over_new;
  logic               over_now;

  // Saturating byte add and limit checks on the committed and updated totals.
  assign sum_wide = {1'b0, total_r} + (TOTAL_W + 1)'(item_r.msg_bytes);
  assign over_new = over_limit(count_nxt, total_nxt, cfg);
  assign over_now = over_limit(count_r, total_r, cfg);

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    total_nxt   = total_r;
    writing_nxt = writing_r;
    armed_nxt   = armed_r;
    ticks_nxt   = ticks_r;
    closed_nxt  = closed_r;
    strobe_nxt  = 1'b0;
    item_nxt    = item_r;
    len_nxt     = len_r;
    out_nxt     = out_r;
    ram_req     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_start) begin
          item_nxt = in_data;
          // A pop of a held message needs the head and the following entry.
          if (in_data.mode == MODE_DONE && count_r != '0) begin
            ram_req.re    = 1'b1;
            ram_req.raddr = head_r;
            state_nxt     = S_LEN;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_LEN: begin
        len_nxt       = ram_rdata.bytes;
        ram_req.re    = 1'b1;
        ram_req.raddr = next_ptr(head_r);
        state_nxt     = S_EXEC;
      end

      S_EXEC: begin
        out_nxt    = '0;
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
        case (item_r.mode)
          MODE_ENQ: begin
            if (!closed_r) begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                out_nxt.dropped = 1'b1;
              end else begin
                ram_req.we            = 1'b1;
                ram_req.waddr         = tail_r;
                ram_req.wdata.handle  = item_r.msg_handle;
                ram_req.wdata.bytes   = item_r.msg_bytes;
                tail_nxt              = next_ptr(tail_r);
                count_nxt             = count_r + CNT_W'(1);
                total_nxt             = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
                if (over_new) begin
                  if (!armed_r) begin
                    armed_nxt = 1'b1;
                    ticks_nxt = cfg.stall_timeout_ticks;
                  end
                end else begin
                  armed_nxt = 1'b0;
                end
                // With no write in progress the queue was empty, so the new
                // message is the head.
                if (!writing_r) begin
                  writing_nxt          = 1'b1;
                  out_nxt.start_write  = 1'b1;
                  out_nxt.write_handle = item_r.msg_handle;
                  out_nxt.write_bytes  = item_r.msg_bytes;
                end
              end
            end
          end

          MODE_DONE: begin
            if (count_r == '0) begin
              writing_nxt = 1'b0;
            end else begin
              head_nxt  = next_ptr(head_r);
              count_nxt = count_r - CNT_W'(1);
              total_nxt = (total_r >= TOTAL_W'(len_r)) ? total_r - TOTAL_W'(len_r) : '0;
              if (count_r != CNT_W'(1)) begin
                writing_nxt          = 1'b1;
                out_nxt.start_write  = 1'b1;
                out_nxt.write_handle = ram_rdata.handle;
                out_nxt.write_bytes  = ram_rdata.bytes;
              end else begin
                writing_nxt = 1'b0;
              end
            end
            if (over_new) begin
              if (!armed_r) begin
                armed_nxt = 1'b1;
                ticks_nxt = cfg.stall_timeout_ticks;
              end
            end else begin
              armed_nxt = 1'b0;
            end
          end

          MODE_TICK: begin
            if (armed_r) begin
              if (ticks_r <= TIMER_W'(1)) begin
                ticks_nxt = '0;
                armed_nxt = 1'b0;
                // Expiry while still over the limit closes the session.
                if (over_now) begin
                  closed_nxt          = 1'b1;
                  out_nxt.close_event = 1'b1;
                  head_nxt            = '0;
                  tail_nxt            = '0;
                  count_nxt           = '0;
                  total_nxt           = '0;
                  writing_nxt         = 1'b0;
                end
              end else begin
                ticks_nxt = ticks_r - TIMER_W'(1);
              end
            end
          end

          default: begin
          end
        endcase
        out_nxt.session_closed  = closed_nxt;
        out_nxt.queued_messages = MAXMSG_W'(count_nxt);
        out_nxt.total_bytes     = total_nxt;
        out_nxt.stall_pending   = armed_nxt;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, queue bookkeeping and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      tail_r    <= '0;
      count_r   <= '0;
      total_r   <= '0;
      writing_r <= 1'b0;
      armed_r   <= 1'b0;
      ticks_r   <= '0;
      closed_r  <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      total_r   <= total_nxt;
      writing_r <= writing_nxt;
      armed_r   <= armed_nxt;
      ticks_r   <= ticks_nxt;
      closed_r  <= closed_nxt;
      strobe_r  <= strobe_nxt;
    end
    item_r <= item_nxt;
    len_r  <= len_nxt;
    out_r  <= out_nxt;
  end

  assign in_busy    = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  // With no write outstanding the queue must be empty.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !writing_r |-> count_r == '0)
    else $error("write idle while messages are queued");

  // An empty queue has its pointers together.
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == tail_r)
    else $error("head and tail differ on an empty queue");

  // The fill count never passes the depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  // A closed session holds nothing.
  a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    closed_r |-> count_r == '0 && total_r == '0)
    else $error("closed session still holds messages");

  // A result follows every execute step.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |=> strobe_r)
    else $error("execute step produced no result");
`endif

endmodule

### design/send_queue_backpressure_guard.sv
// Top level of the send queue guard: configuration registers, controller and message memory.
//
//   channel  direction  handshake               payload
//   in_      input      in_start & !in_busy     in_data (in_t)
//   out_     output     out_strobe, one cycle   out_data (out_t)
//   cfg_     input      cfg_valid & cfg_ready   cfg_index, cfg_data
//
// An enqueue, a tick or a write complete on an empty queue goes from acceptance straight to
// the execute step; a write complete that pops passes a length step first, set by the two reads
// of the single memory read port (head length, then the next head).
// The result shows in the cycle after the execute step; the next beat may be taken then.
// Synchronous active-low reset clears the queue bookkeeping; the memory is not cleared.
// The receiver cannot stall; cfg_ready is always high.
`timescale 1ns / 1ps

module send_queue_backpressure_guard
  import sqbg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_start,
  output logic                  in_busy,
  input  in_t                   in_data,
  output logic                  out_strobe,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t     cfg_r;
  ram_req_t ram_req;
  entry_t   ram_rdata;

  assign cfg_ready = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_messages        <= '0;
      cfg_r.max_bytes           <= '0;
      cfg_r.stall_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_MSG:   cfg_r.max_messages        <= MAXMSG_W'(cfg_data);
        CFG_MAX_BYTES: cfg_r.max_bytes           <= TOTAL_W'(cfg_data);
        CFG_TIMEOUT:   cfg_r.stall_timeout_ticks <= TIMER_W'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  // Command sequencer and queue state.
  sqbg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_start   (in_start),
    .in_busy    (in_busy),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .ram_req    (ram_req),
    .ram_rdata  (ram_rdata),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // Message store: handle and length of each queued message.
  sqbg_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W),
    .AW    (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule
